[design/swp90_pkg.sv]
// ----------------------------------------------------------------------------
// swp90_pkg: shared constants and helpers for the sliding window p90 timeout
// Window depth, field widths, register indexes and the rank helper.
// ----------------------------------------------------------------------------
package swp90_pkg;

    // Window geometry
    localparam int WINDOW_DEPTH = 10;
    localparam int IDX_W        = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
    localparam int CNT_W        = $clog2(WINDOW_DEPTH + 1);

    // Field widths
    localparam int SAMPLE_W  = 16;
    localparam int THR_W     = 17;
    localparam int COUNT_W   = 4;
    localparam int CFG_IDX_W = 4;
    localparam int CFG_W     = 16;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_DEFAULT_THR = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_EXTRA   = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_THR     = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_THR     = CFG_IDX_W'(3);

    // Reset values of the registers
    localparam logic [CFG_W-1:0] RST_DEFAULT_THR = CFG_W'(600);
    localparam logic [CFG_W-1:0] RST_MIN_EXTRA   = CFG_W'(120);
    localparam logic [CFG_W-1:0] RST_MIN_THR     = CFG_W'(0);
    localparam logic [CFG_W-1:0] RST_MAX_THR     = CFG_W'(0);

    // Width of the rank numerator (n-1)*9+5
    localparam int RK_W = CNT_W + 4;

    // Rank of the 90th percentile among n samples: floor(((n-1)*9+5)/10).
    // Divide by ten as multiply by 205 and shift by 11; exact for this range.
    function automatic logic [CNT_W-1:0] rank_of(input logic [CNT_W-1:0] n);
        logic [RK_W-1:0]   x;
        logic [RK_W+7:0]   p;
        x = RK_W'(n) - RK_W'(1);
        x = x * RK_W'(9) + RK_W'(5);
        p = (RK_W + 8)'(x) * (RK_W + 8)'(205);
        return CNT_W'(p >> 11);
    endfunction

endpackage

[design/swp90_ram.sv]
// ----------------------------------------------------------------------------
// swp90_ram: generic single write, single read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module swp90_ram #(
    parameter int  WIDTH = 16,
    parameter int  DEPTH = 10,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[design/sliding_window_p90_timeout_unit.sv]
// ----------------------------------------------------------------------------
// sliding_window_p90_timeout_unit: adaptive timeout from a sample window
// Empty window: the default threshold goes straight to the output stage;
// otherwise a rank search walks candidates and compares each against all n
// stored samples through the single RAM read port.
// Throughput: one transaction at a time; ready only in the idle state.
// Reset (synchronous, active low) clears counters, sequencer and output valid
// and loads the register reset values; ring contents are left unwritten.
// ----------------------------------------------------------------------------
module sliding_window_p90_timeout_unit (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // Sample channel
    input  logic                               i_valid,
    output logic                               o_ready,
    input  logic [swp90_pkg::SAMPLE_W-1:0]     i_sample_seconds,
    // Result channel
    output logic                               o_valid,
    input  logic                               i_ready,
    output logic [swp90_pkg::THR_W-1:0]        o_threshold,
    output logic [swp90_pkg::COUNT_W-1:0]      o_sample_count,
    // Configuration channel
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [swp90_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [swp90_pkg::CFG_W-1:0]        i_cfg_data
);

    import swp90_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_CAND,
        S_LOAD,
        S_SCAN,
        S_SUM,
        S_CLAMP,
        S_PUSH
    } t_state;

    t_state r_state;

    logic [CFG_W-1:0]    r_def_thr;
    logic [CFG_W-1:0]    r_min_extra;
    logic [CFG_W-1:0]    r_min_thr;
    logic [CFG_W-1:0]    r_max_thr;

    logic [CNT_W-1:0]    r_fill;
    logic [IDX_W-1:0]    r_slot;
    logic [IDX_W-1:0]    r_i;
    logic [IDX_W-1:0]    r_j;
    logic [CNT_W-1:0]    r_less;
    logic [CNT_W-1:0]    r_leq;
    logic [CNT_W-1:0]    r_rank;
    logic [SAMPLE_W-1:0] r_cand;
    logic [THR_W-1:0]    r_sum;
    logic [THR_W-1:0]    r_res;
    logic [THR_W-1:0]    r_out_thr;
    logic [COUNT_W-1:0]  r_out_cnt;
    logic                r_out_valid;

    logic                w_accept;
    logic                w_we;
    logic [IDX_W-1:0]    w_raddr;
    logic [SAMPLE_W-1:0] w_rdata;
    logic [IDX_W-1:0]    w_last_idx;
    logic                w_last;
    logic [CNT_W-1:0]    n_less;
    logic [CNT_W-1:0]    n_leq;
    logic [THR_W-1:0]    w_half;
    logic [THR_W-1:0]    w_extra;
    logic [THR_W-1:0]    w_lo;

    // Handshake
    assign o_ready     = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign w_accept    = i_valid && o_ready;
    assign w_we        = w_accept && (i_sample_seconds != '0);

    // Scan bookkeeping: running counts including the entry now on the read port
    assign w_last_idx = IDX_W'(r_fill - CNT_W'(1));
    assign w_last     = (r_j == w_last_idx);
    assign n_less     = r_less + CNT_W'(w_rdata < r_cand);
    assign n_leq      = r_leq + CNT_W'(w_rdata <= r_cand);

    // Read address for the next cycle
    always_comb begin
        case (r_state)
            S_CAND:  w_raddr = r_i;
            S_LOAD:  w_raddr = '0;
            S_SCAN:  w_raddr = w_last ? '0 : r_j + IDX_W'(1);
            default: w_raddr = r_i;
        endcase
    end

    // Margin: max(min_extra, p90/2)
    assign w_half  = THR_W'(r_cand >> 1);
    assign w_extra = (THR_W'(r_min_extra) > w_half) ? THR_W'(r_min_extra) : w_half;

    // Lower bound
    assign w_lo = (r_sum < THR_W'(r_min_thr)) ? THR_W'(r_min_thr) : r_sum;

    // Sample ring
    swp90_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (WINDOW_DEPTH)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_slot),
        .i_wdata (i_sample_seconds),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_def_thr   <= RST_DEFAULT_THR;
            r_min_extra <= RST_MIN_EXTRA;
            r_min_thr   <= RST_MIN_THR;
            r_max_thr   <= RST_MAX_THR;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_DEFAULT_THR: r_def_thr   <= i_cfg_data;
                CFG_MIN_EXTRA:   r_min_extra <= i_cfg_data;
                CFG_MIN_THR:     r_min_thr   <= i_cfg_data;
                CFG_MAX_THR:     r_max_thr   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Sequencer, window bookkeeping and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_fill      <= '0;
            r_slot      <= '0;
            r_i         <= '0;
            r_j         <= '0;
            r_less      <= '0;
            r_leq       <= '0;
            r_rank      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // Drop the result once taken, unless a new one loads in its place
            if (r_out_valid && i_ready && (r_state != S_PUSH)) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        if (w_we) begin
                            r_slot <= (r_slot == IDX_W'(WINDOW_DEPTH - 1)) ?
                                      '0 : r_slot + IDX_W'(1);
                            if (r_fill != CNT_W'(WINDOW_DEPTH)) begin
                                r_fill <= r_fill + CNT_W'(1);
                            end
                        end
                        r_state <= S_CHECK;
                    end
                end
                S_CHECK: begin
                    // Empty window returns the default with no bounds
                    if (r_fill == '0) begin
                        r_res   <= THR_W'(r_def_thr);
                        r_state <= S_PUSH;
                    end else begin
                        r_rank  <= rank_of(r_fill);
                        r_i     <= '0;
                        r_state <= S_CAND;
                    end
                end
                S_CAND: begin
                    r_state <= S_LOAD;
                end
                S_LOAD: begin
                    // Hold the candidate and start the compare sweep
                    r_cand  <= w_rdata;
                    r_j     <= '0;
                    r_less  <= '0;
                    r_leq   <= '0;
                    r_state <= S_SCAN;
                end
                S_SCAN: begin
                    if (!w_last) begin
                        r_less <= n_less;
                        r_leq  <= n_leq;
                        r_j    <= r_j + IDX_W'(1);
                    end else if ((n_less <= r_rank) && (r_rank < n_leq)) begin
                        r_state <= S_SUM;
                    end else begin
                        r_i     <= r_i + IDX_W'(1);
                        r_state <= S_CAND;
                    end
                end
                S_SUM: begin
                    r_sum   <= THR_W'(r_cand) + w_extra;
                    r_state <= S_CLAMP;
                end
                S_CLAMP: begin
                    // Apply the upper bound last so it wins
                    if ((r_max_thr != '0) && (w_lo > THR_W'(r_max_thr))) begin
                        r_res <= THR_W'(r_max_thr);
                    end else begin
                        r_res <= w_lo;
                    end
                    r_state <= S_PUSH;
                end
                S_PUSH: begin
                    // Load the output register once it is free
                    if (!r_out_valid || i_ready) begin
                        r_out_thr   <= r_res;
                        r_out_cnt   <= COUNT_W'(r_fill);
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_valid        = r_out_valid;
    assign o_threshold    = r_out_thr;
    assign o_sample_count = r_out_cnt;

endmodule

[dv/swp90_checker.sv]
// ----------------------------------------------------------------------------
// swp90_checker: result checker for the sliding window p90 timeout unit
// Watches the sample, result and configuration channels, keeps its own copy
// of the window and registers, predicts the timeout of every accepted sample
// and compares each result transaction against the oldest prediction.
// ----------------------------------------------------------------------------
module swp90_checker (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // Sample channel
    input  logic                               i_sample_valid,
    input  logic                               i_sample_ready,
    input  logic [swp90_pkg::SAMPLE_W-1:0]     i_sample_seconds,
    // Result channel
    input  logic                               i_result_valid,
    input  logic                               i_result_ready,
    input  logic [swp90_pkg::THR_W-1:0]        i_threshold,
    input  logic [swp90_pkg::COUNT_W-1:0]      i_sample_count,
    // Configuration channel
    input  logic                               i_cfg_valid,
    input  logic                               i_cfg_ready,
    input  logic [swp90_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [swp90_pkg::CFG_W-1:0]        i_cfg_data,
    // Status to the testbench top
    output logic [31:0]                        o_fail_count,
    output logic [31:0]                        o_pending
);

    import swp90_pkg::*;

    typedef struct {
        logic [THR_W-1:0]   threshold;
        logic [COUNT_W-1:0] count;
    } t_timeout_result;

    // Shadow registers
    logic [CFG_W-1:0] default_thr;
    logic [CFG_W-1:0] min_extra;
    logic [CFG_W-1:0] min_thr;
    logic [CFG_W-1:0] max_thr;

    // Shadow window
    logic [SAMPLE_W-1:0] recent_durations [WINDOW_DEPTH];
    int                  held_count;
    int                  next_slot;

    t_timeout_result     timeout_due [$];
    int                  fail_total = 0;

    // Pick the 90th percentile of the held samples and apply margin and bounds
    function automatic logic [THR_W-1:0] predict_timeout();
        logic [SAMPLE_W-1:0] sorted [WINDOW_DEPTH];
        logic [SAMPLE_W-1:0] key;
        logic [THR_W-1:0]    p90;
        logic [THR_W-1:0]    margin;
        logic [THR_W-1:0]    total;
        int                  rank;
        int                  j;
        if (held_count == 0) begin
            return THR_W'(default_thr);
        end
        for (int i = 0; i < held_count; i++) begin
            sorted[i] = recent_durations[i];
        end
        for (int i = 1; i < held_count; i++) begin
            key = sorted[i];
            j = i;
            while (j > 0 && sorted[j-1] > key) begin
                sorted[j] = sorted[j-1];
                j--;
            end
            sorted[j] = key;
        end
        rank = ((held_count - 1) * 9 + 5) / 10;
        if (rank > held_count - 1) begin
            rank = held_count - 1;
        end
        p90 = THR_W'(sorted[rank]);
        margin = p90 >> 1;
        if (THR_W'(min_extra) > margin) begin
            margin = THR_W'(min_extra);
        end
        total = p90 + margin;
        if (total < THR_W'(min_thr)) begin
            total = THR_W'(min_thr);
        end
        if (max_thr != '0 && total > THR_W'(max_thr)) begin
            total = THR_W'(max_thr);
        end
        return total;
    endfunction

    always @(posedge i_clk) begin
        t_timeout_result due;
        if (!i_rst_n) begin
            default_thr = RST_DEFAULT_THR;
            min_extra   = RST_MIN_EXTRA;
            min_thr     = RST_MIN_THR;
            max_thr     = RST_MAX_THR;
            held_count  = 0;
            next_slot   = 0;
            timeout_due.delete();
        end else begin
            // Match a result transaction against the oldest prediction
            if (i_result_valid && i_result_ready) begin
                if (timeout_due.size() == 0) begin
                    $error("result with no pending sample: threshold %0d, sample_count %0d",
                           i_threshold, i_sample_count);
                    fail_total++;
                end else begin
                    due = timeout_due.pop_front();
                    if (i_threshold !== due.threshold) begin
                        $error("threshold mismatch: expected %0d, actual %0d",
                               due.threshold, i_threshold);
                        fail_total++;
                    end
                    if (i_sample_count !== due.count) begin
                        $error("sample_count mismatch: expected %0d, actual %0d",
                               due.count, i_sample_count);
                        fail_total++;
                    end
                end
            end

            // Track register writes; unknown indexes drop
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_DEFAULT_THR: default_thr = i_cfg_data;
                    CFG_MIN_EXTRA:   min_extra   = i_cfg_data;
                    CFG_MIN_THR:     min_thr     = i_cfg_data;
                    CFG_MAX_THR:     max_thr     = i_cfg_data;
                    default: ;
                endcase
            end

            // Store a nonzero sample over the oldest entry, then predict
            if (i_sample_valid && i_sample_ready) begin
                if (i_sample_seconds != '0) begin
                    recent_durations[next_slot] = i_sample_seconds;
                    next_slot = (next_slot + 1) % WINDOW_DEPTH;
                    if (held_count < WINDOW_DEPTH) begin
                        held_count++;
                    end
                end
                due.threshold = predict_timeout();
                due.count     = COUNT_W'(held_count);
                timeout_due   = {timeout_due, due};
            end
        end
        o_fail_count <= fail_total;
        o_pending    <= timeout_due.size();
    end

endmodule

[dv/tb_sliding_window_p90_timeout_unit.sv]
// ----------------------------------------------------------------------------
// tb_sliding_window_p90_timeout_unit: testbench for the p90 timeout unit
// Drives samples and register writes with random gaps and result stalls;
// a directed opening covers empty-window queries, window wrap and the
// margin and bound extremes, then random phases sweep register settings.
// ----------------------------------------------------------------------------
module tb_sliding_window_p90_timeout_unit;

    import swp90_pkg::*;

    // Indexes outside the register map; writes there must be dropped
    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_UNUSED = CFG_MAX_THR + 1'b1;
    localparam logic [CFG_IDX_W-1:0] CFG_LAST_UNUSED  = '1;

    // Slowest rank search of the block, plus a margin for the handshake
    localparam int SETTLE_CYCLES = WINDOW_DEPTH * (WINDOW_DEPTH + 2) + 5 + 10;
    // Idle cycles tolerated between transactions: a full search plus long
    // random stalls at the heaviest idle rate stay far below this
    localparam int QUIET_LIMIT   = 20000;
    localparam int PHASE_COUNT   = 6;
    localparam int PHASE_ITEMS   = 172;

    logic                   i_clk            = 1'b0;
    logic                   i_rst_n          = 1'b0;
    logic                   i_valid          = 1'b0;
    logic [SAMPLE_W-1:0]    i_sample_seconds = '0;
    logic                   i_ready          = 1'b0;
    logic                   i_cfg_valid      = 1'b0;
    logic [CFG_IDX_W-1:0]   i_cfg_index      = '0;
    logic [CFG_W-1:0]       i_cfg_data       = '0;
    logic                   o_ready;
    logic                   o_valid;
    logic [THR_W-1:0]       o_threshold;
    logic [COUNT_W-1:0]     o_sample_count;
    logic                   o_cfg_ready;

    logic [31:0]            fail_count;
    logic [31:0]            results_owed;
    int                     send_idle_pct = 0;
    int                     recv_idle_pct = 0;
    int                     quiet_cycles  = 0;

    sliding_window_p90_timeout_unit i_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_sample_seconds (i_sample_seconds),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_threshold      (o_threshold),
        .o_sample_count   (o_sample_count),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data)
    );

    swp90_checker u_checker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_sample_valid   (i_valid),
        .i_sample_ready   (o_ready),
        .i_sample_seconds (i_sample_seconds),
        .i_result_valid   (o_valid),
        .i_result_ready   (i_ready),
        .i_threshold      (o_threshold),
        .i_sample_count   (o_sample_count),
        .i_cfg_valid      (i_cfg_valid),
        .i_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .o_fail_count     (fail_count),
        .o_pending        (results_owed)
    );

    // Clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Stall the result channel at random
    always @(posedge i_clk) begin
        i_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Abort when no transaction completes for too long
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready) || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // Present one sample; hold valid high afterwards unless a gap follows
    task automatic push_sample(input logic [SAMPLE_W-1:0] seconds);
        if ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
        i_valid          <= 1'b1;
        i_sample_seconds <= seconds;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
    endtask

    // Drop sample valid and wait until every predicted result has arrived
    task automatic wait_results_in();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (results_owed != 0) @(posedge i_clk);
    endtask

    task automatic put_reg(input logic [CFG_IDX_W-1:0] index, input logic [CFG_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
    endtask

    // Write all four registers plus one write to an unmapped index, when idle
    task automatic program_regs(input logic [CFG_W-1:0] dflt, input logic [CFG_W-1:0] extra,
                                input logic [CFG_W-1:0] lower, input logic [CFG_W-1:0] upper,
                                input logic [CFG_IDX_W-1:0] stray_index,
                                input logic [CFG_W-1:0] stray_data);
        wait_results_in();
        put_reg(CFG_DEFAULT_THR, dflt);
        put_reg(CFG_MIN_EXTRA, extra);
        put_reg(CFG_MIN_THR, lower);
        put_reg(CFG_MAX_THR, upper);
        put_reg(stray_index, stray_data);
        i_cfg_valid <= 1'b0;
    endtask

    // Register value biased toward the extremes and the range of the samples
    function automatic logic [CFG_W-1:0] pick_reg_value();
        case ($urandom_range(4))
            0:       return '0;
            1:       return '1;
            2:       return CFG_W'($urandom_range(400, 1));
            3:       return CFG_W'($urandom_range(4000, 1));
            default: return CFG_W'($urandom);
        endcase
    endfunction

    initial begin
        logic [SAMPLE_W-1:0] seconds;
        logic [SAMPLE_W-1:0] last_seconds;
        int                  pick;

        last_seconds = 16'd1;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Empty window: reset default, then both extremes of the default
        push_sample('0);
        program_regs('1, RST_MIN_EXTRA, RST_MIN_THR, RST_MAX_THR, CFG_FIRST_UNUSED, '0);
        push_sample('0);
        program_regs('0, RST_MIN_EXTRA, RST_MIN_THR, RST_MAX_THR, CFG_LAST_UNUSED, '1);
        push_sample('0);

        // Smallest and largest samples, a query, then fill and wrap the window
        program_regs(RST_DEFAULT_THR, RST_MIN_EXTRA, RST_MIN_THR, RST_MAX_THR,
                     CFG_FIRST_UNUSED, 16'h5A5A);
        push_sample(16'd1);
        push_sample('1);
        push_sample('0);
        for (int k = 0; k < WINDOW_DEPTH; k++) begin
            push_sample(SAMPLE_W'(100 * (k + 1) + 7));
        end
        push_sample('0);

        // Widest result: largest percentile with the largest margin
        program_regs(RST_DEFAULT_THR, '1, '1, '0, CFG_LAST_UNUSED, 16'hA5A5);
        push_sample('1);
        push_sample('1);

        // Lower bound above a nonzero upper bound: upper bound wins
        program_regs(RST_DEFAULT_THR, '0, 16'd50000, 16'd1000, CFG_FIRST_UNUSED, '1);
        push_sample('0);

        // Half the percentile as margin, cut by the upper bound
        program_regs(RST_DEFAULT_THR, '0, '0, '1, CFG_LAST_UNUSED, '0);
        push_sample('0);

        // Random phases: sender-light, receiver-light, then no idling
        for (int phase = 0; phase < PHASE_COUNT; phase++) begin
            if (phase < 2) begin
                send_idle_pct = 8;
                recv_idle_pct = 84;
            end else if (phase < 4) begin
                send_idle_pct = 84;
                recv_idle_pct = 8;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            program_regs(pick_reg_value(), pick_reg_value(), pick_reg_value(),
                         ($urandom_range(2) == 0) ? '0 : pick_reg_value(),
                         CFG_IDX_W'($urandom_range(CFG_LAST_UNUSED, CFG_FIRST_UNUSED)),
                         CFG_W'($urandom));
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                pick = $urandom_range(99);
                if (pick < 12) begin
                    seconds = '0;
                end else if (pick < 18) begin
                    seconds = ($urandom_range(1) == 1) ? '1 : 16'd1;
                end else if (pick < 28) begin
                    seconds = last_seconds;
                end else if (pick < 60) begin
                    seconds = SAMPLE_W'($urandom_range(300, 1));
                end else if (pick < 82) begin
                    seconds = SAMPLE_W'($urandom_range(4000, 1));
                end else begin
                    seconds = SAMPLE_W'($urandom_range(16'hFFFF, 1));
                end
                last_seconds = seconds;
                push_sample(seconds);
            end
        end

        // Drain, let the block settle, then report
        wait_results_in();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
